/* hw/rtl/bbpt_pkg.sv */
// Shared types and constants for the beep burst pattern timer.
package bbpt_pkg;

  localparam int CntW      = 16;
  localparam int OpW       = 2;
  localparam int InDataW   = 56;
  localparam int OutDataW  = 24;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic            force_req;
    logic [CntW-1:0] off_ticks;
    logic [CntW-1:0] on_ticks;
    logic [CntW-1:0] repeat_count;
    op_t             op;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0] on_remaining;
    logic            busy_res;
    logic            drive;
  } result_t;

  typedef struct packed {
    logic fire;
    logic advance;
  } stage_ctrl_t;

endpackage

/* hw/rtl/beep_burst_pattern_timer_top.sv */
// Top level of the beep burst pattern timer.
//
// The input channel carries one command per beat: a 1 ms tick, a set of a
// new burst pattern, a clear or a no-op. The op code travels on in_tuser; the pattern
// fields and the force request travel on in_tdata. Every accepted beat gives
// exactly one result beat on the output channel with the drive level, the
// busy flag and the remaining on time after that command.
// A beat accepted into the input register is held there until the core works it;
// working it also loads the result register, which offers its result. One beat
// is taken in every cycle while the output side keeps up; the rate is set by the
// combinational update of the pattern counters.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; after that in_tready falls until
// the stalled result is taken. Synchronous reset clears all counters, the
// busy flag and the drive level and empties both stages.
module beep_burst_pattern_timer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // repeat_count[15:0], on_ticks[31:16], off_ticks[47:32], force_req[48], zeros
  input  logic [bbpt_pkg::InDataW-1:0] in_tdata,
  // op[1:0]
  input  logic [bbpt_pkg::OpW-1:0]     in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // drive[0], busy_res[1], on_remaining[17:2], zeros
  output logic [bbpt_pkg::OutDataW-1:0] out_tdata
);

  logic                  out_valid_r, out_valid_nxt;
  logic                  item_valid;
  bbpt_pkg::item_t       item;
  bbpt_pkg::result_t     result;
  bbpt_pkg::stage_ctrl_t ctrl;

  assign ctrl.advance = !out_valid_r || out_tready;
  assign ctrl.fire    = item_valid && ctrl.advance;

  bbpt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (ctrl.advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bbpt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .item   (item),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bbpt_pkg::OutDataW - $bits(bbpt_pkg::result_t)){1'b0}}, result};

endmodule

/* hw/rtl/bbpt_in_reg.sv */
// Input register stage: captures one beat and holds it until the core takes it.
module bbpt_in_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [bbpt_pkg::InDataW-1:0] in_tdata,
  input  logic [bbpt_pkg::OpW-1:0]     in_tuser,
  input  logic                    advance,
  output logic                    item_valid,
  output bbpt_pkg::item_t         item
);

  logic            valid_r;
  logic            valid_nxt;
  bbpt_pkg::item_t item_r;
  logic            load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op           <= bbpt_pkg::op_t'(in_tuser);
      item_r.repeat_count <= in_tdata[15:0];
      item_r.on_ticks     <= in_tdata[31:16];
      item_r.off_ticks    <= in_tdata[47:32];
      item_r.force_req    <= in_tdata[48];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* hw/rtl/bbpt_core.sv */
// Pattern state, its next-state logic and the result register.
module bbpt_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bbpt_pkg::stage_ctrl_t ctrl,
  input  bbpt_pkg::item_t       item,
  output bbpt_pkg::result_t     result
);

  logic [bbpt_pkg::CntW-1:0] on_left_r, on_left_nxt;
  logic [bbpt_pkg::CntW-1:0] off_left_r, off_left_nxt;
  logic [bbpt_pkg::CntW-1:0] repeats_left_r, repeats_left_nxt;
  logic [bbpt_pkg::CntW-1:0] on_reload_r, on_reload_nxt;
  logic [bbpt_pkg::CntW-1:0] off_reload_r, off_reload_nxt;
  logic                      busy_r, busy_nxt;
  logic                      drive_r, drive_nxt;
  bbpt_pkg::result_t         result_r;
  logic                      busy_eff;

  always_comb begin
    on_left_nxt      = on_left_r;
    off_left_nxt     = off_left_r;
    repeats_left_nxt = repeats_left_r;
    on_reload_nxt    = on_reload_r;
    off_reload_nxt   = off_reload_r;
    busy_nxt         = busy_r;
    drive_nxt        = drive_r;
    busy_eff         = busy_r && !item.force_req;
    case (item.op)
      bbpt_pkg::OP_TICK: begin
        if (on_left_r != '0) begin
          on_left_nxt = on_left_r - 1'b1;
          busy_nxt    = 1'b1;
          drive_nxt   = 1'b1;
        end else if (repeats_left_r > 16'd1) begin
          if (off_left_r != '0) begin
            off_left_nxt = off_left_r - 1'b1;
            drive_nxt    = 1'b0;
          end else begin
            off_left_nxt     = off_reload_r;
            on_left_nxt      = on_reload_r;
            repeats_left_nxt = repeats_left_r - 1'b1;
          end
        end else begin
          busy_nxt  = 1'b0;
          drive_nxt = 1'b0;
        end
      end
      bbpt_pkg::OP_SET: begin
        busy_nxt = busy_eff;
        if (!busy_eff) begin
          repeats_left_nxt = item.repeat_count;
          on_left_nxt      = item.on_ticks;
          on_reload_nxt    = item.on_ticks;
          off_left_nxt     = item.off_ticks;
          off_reload_nxt   = item.off_ticks;
        end
      end
      bbpt_pkg::OP_CLEAR: begin
        busy_nxt         = 1'b0;
        repeats_left_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_left_r      <= '0;
      off_left_r     <= '0;
      repeats_left_r <= '0;
      on_reload_r    <= '0;
      off_reload_r   <= '0;
      busy_r         <= 1'b0;
      drive_r        <= 1'b0;
    end else if (ctrl.fire) begin
      on_left_r      <= on_left_nxt;
      off_left_r     <= off_left_nxt;
      repeats_left_r <= repeats_left_nxt;
      on_reload_r    <= on_reload_nxt;
      off_reload_r   <= off_reload_nxt;
      busy_r         <= busy_nxt;
      drive_r        <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      result_r.drive        <= drive_nxt;
      result_r.busy_res     <= busy_nxt;
      result_r.on_remaining <= on_left_nxt;
    end
  end

  assign result = result_r;

endmodule

/* hw/rtl/bbpt_checker.sv */
// Port-level checks for the beep burst pattern timer, bound to the top level.
module bbpt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [bbpt_pkg::InDataW-1:0]  in_tdata,
  input logic [bbpt_pkg::OpW-1:0]      in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bbpt_pkg::OutDataW-1:0] out_tdata
);

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata) ^ (^in_tuser);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result beat changed or was dropped.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result beat shown straight after reset.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[bbpt_pkg::OutDataW-1:18] == '0)
    else $error("Padding bits of the result beat are not zero.");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("Input stalled although the output side is taking beats.");

endmodule

bind beep_burst_pattern_timer_top bbpt_checker u_bbpt_checker (.*);

/* dv/tb_top.sv */
// Self-checking stream testbench for the beep burst pattern timer.
`timescale 1ns / 100ps

module tb_top;
  import bbpt_pkg::*;

  localparam int StallLimit = 1000;
  localparam int CalmTail   = 40;
  localparam int ItemGoal   = 400;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic [OpW-1:0]      in_tuser   = OP_NONE;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  item_t   pending_q[$];
  result_t burst_exp_q[$];

  logic [CntW-1:0] on_cnt, off_cnt, rep_cnt, on_len, off_len;
  logic            busy_lvl, drive_lvl;

  int   beats_in     = 0;
  int   beats_total  = 0;
  int   beat_errors  = 0;
  int   results_seen = 0;
  int   idle_cycles  = 0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   item_count   = 0;
  logic in_taken     = 1'b0;

  beep_burst_pattern_timer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic add_item(input op_t op, input logic [CntW-1:0] cnt,
                          input logic [CntW-1:0] on_t, input logic [CntW-1:0] off_t,
                          input logic frc);
    item_t it;
    it.op           = op;
    it.repeat_count = cnt;
    it.on_ticks     = on_t;
    it.off_ticks    = off_t;
    it.force_req    = frc;
    pending_q.push_back(it);
    if (op != OP_NONE) item_count++;
  endtask

  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      add_item(OP_TICK, CntW'($urandom), CntW'($urandom), CntW'($urandom),
               1'($urandom_range(0, 1)));
    end
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 3))
      0: add_item(OP_CLEAR, CntW'($urandom), CntW'($urandom), CntW'($urandom),
                  1'($urandom_range(0, 1)));
      1: add_item(OP_SET, CntW'($urandom), CntW'($urandom), CntW'($urandom), 1'b0);
      2: add_item(OP_SET, CntW'($urandom_range(0, 4)), CntW'($urandom_range(0, 4)),
                  CntW'($urandom_range(0, 4)), 1'b1);
      default: add_item(OP_NONE, CntW'($urandom), CntW'($urandom), CntW'($urandom),
                        1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic step_burst(input item_t it, output result_t res);
    case (it.op)
      OP_TICK: begin
        if (on_cnt != '0) begin
          on_cnt    = on_cnt - 1'b1;
          busy_lvl  = 1'b1;
          drive_lvl = 1'b1;
        end else if (rep_cnt > 16'd1) begin
          if (off_cnt != '0) begin
            off_cnt   = off_cnt - 1'b1;
            drive_lvl = 1'b0;
          end else begin
            off_cnt = off_len;
            on_cnt  = on_len;
            rep_cnt = rep_cnt - 1'b1;
          end
        end else begin
          busy_lvl  = 1'b0;
          drive_lvl = 1'b0;
        end
      end
      OP_SET: begin
        if (it.force_req) busy_lvl = 1'b0;
        if (!busy_lvl) begin
          rep_cnt = it.repeat_count;
          on_cnt  = it.on_ticks;
          on_len  = it.on_ticks;
          off_cnt = it.off_ticks;
          off_len = it.off_ticks;
        end
      end
      OP_CLEAR: begin
        busy_lvl = 1'b0;
        rep_cnt  = '0;
      end
      default: ;
    endcase
    res.drive        = drive_lvl;
    res.busy_res     = busy_lvl;
    res.on_remaining = on_cnt;
  endtask

  task automatic report_mismatch(input result_t want, input result_t got);
    beat_errors++;
    if (beat_errors <= 10) begin
      $display("result %0d: expected drive %0b busy %0b on_remaining %0d, ",
               results_seen, want.drive, want.busy_res, want.on_remaining,
               "got drive %0b busy %0b on_remaining %0d",
               got.drive, got.busy_res, got.on_remaining);
    end
  endtask

  always @(posedge clk) begin : mon_blk
    item_t   it;
    result_t res;
    result_t got;
    if (!rst_n) begin
      on_cnt    = '0;
      off_cnt   = '0;
      rep_cnt   = '0;
      on_len    = '0;
      off_len   = '0;
      busy_lvl  = 1'b0;
      drive_lvl = 1'b0;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        it.op           = op_t'(in_tuser);
        it.repeat_count = in_tdata[15:0];
        it.on_ticks     = in_tdata[31:16];
        it.off_ticks    = in_tdata[47:32];
        it.force_req    = in_tdata[48];
        step_burst(it, res);
        burst_exp_q.push_back(res);
        beats_in++;
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[17:0]);
        if (burst_exp_q.size() == 0) begin
          beat_errors++;
          if (beat_errors <= 10) begin
            $display("result %0d: unexpected beat drive %0b busy %0b on_remaining %0d",
                     results_seen, got.drive, got.busy_res, got.on_remaining);
          end
        end else begin
          res = burst_exp_q.pop_front();
          if (got.drive !== res.drive || got.busy_res !== res.busy_res ||
              got.on_remaining !== res.on_remaining) begin
            report_mismatch(res, got);
          end
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("beep_burst_pattern_timer_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin : drv_blk
    item_t it;
    logic  calm;
    calm = pending_q.size() < CalmTail;
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          in_tdata  <= {7'b0, it.force_req, it.off_ticks, it.on_ticks, it.repeat_count};
          in_tuser  <= it.op;
          in_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stim_blk
    logic [CntW-1:0] cnt, on_t, off_t;
    int              n;

    add_item(OP_TICK, 16'd0, 16'd0, 16'd0, 1'b0);
    add_item(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_item(OP_SET, 16'd0, 16'd0, 16'd0, 1'b0);
    add_item(OP_TICK, 16'd0, 16'd0, 16'd0, 1'b0);
    add_item(OP_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_ticks(2);
    add_item(OP_SET, 16'd2, 16'd1, 16'd1, 1'b0);
    add_ticks(1);
    add_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_ticks(1);
    add_item(OP_SET, 16'd2, 16'd1, 16'd1, 1'b1);
    add_ticks(5);
    add_item(OP_SET, 16'd3, 16'd0, 16'd0, 1'b1);
    add_ticks(4);
    add_item(OP_NONE, 16'd0, 16'd0, 16'd0, 1'b0);
    add_item(OP_CLEAR, 16'd0, 16'd0, 16'd0, 1'b0);
    add_ticks(1);

    while (item_count < ItemGoal) begin
      case ($urandom_range(0, 9))
        7: begin
          add_item(OP_SET, CntW'($urandom), CntW'($urandom), CntW'($urandom),
                   1'($urandom_range(0, 1)));
          add_ticks($urandom_range(0, 3));
        end
        8: begin
          add_item(OP_CLEAR, CntW'($urandom), CntW'($urandom), CntW'($urandom),
                   1'($urandom_range(0, 1)));
          add_ticks($urandom_range(0, 4));
        end
        9: add_item(OP_NONE, CntW'($urandom), CntW'($urandom), CntW'($urandom),
                    1'($urandom_range(0, 1)));
        default: begin
          cnt   = CntW'($urandom_range(0, 4));
          on_t  = CntW'($urandom_range(0, 4));
          off_t = CntW'($urandom_range(0, 4));
          add_item(OP_SET, cnt, on_t, off_t, $urandom_range(0, 3) != 0);
          n = cnt * (on_t + off_t + 1) + $urandom_range(0, 3);
          if (n > 40) n = 40;
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) add_noise();
            else add_ticks(1);
          end
        end
      endcase
    end
    beats_total = pending_q.size();

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    while (beats_in != beats_total || burst_exp_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (beat_errors == 0 && burst_exp_q.size() == 0) begin
      $display("beep_burst_pattern_timer_top: match");
    end else begin
      $display("beep_burst_pattern_timer_top: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bbpt_pkg.sv
hw/rtl/bbpt_in_reg.sv
hw/rtl/bbpt_core.sv
hw/rtl/beep_burst_pattern_timer_top.sv
hw/rtl/bbpt_checker.sv
dv/tb_top.sv
